// File: rtl/sitoa_pkg.sv
package sitoa_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'h2D;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX   = 4'd9;
    localparam logic [DIGIT_W-1:0] ADJ_MIN     = 4'd5;
    localparam logic [DIGIT_W-1:0] ADJ_ADD     = 4'd3;

    // per-cycle command broadcast to every digit cell
    typedef struct packed {
        logic clear;   // zero the digit
        logic conv;    // add-3 correction and shift in the neighbor's carry
        logic shift;   // take the lower neighbor's digit (output drain)
    } t_cell_ctrl;

endpackage

// File: rtl/sitoa_cell.sv
module sitoa_cell
    import sitoa_pkg::*;
(
    input  logic               i_clk,
    input  t_cell_ctrl         i_ctrl,
    input  logic               i_carry,
    input  logic [DIGIT_W-1:0] i_digit,
    output logic               o_carry,
    output logic [DIGIT_W-1:0] o_digit
);

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    logic [DIGIT_W-1:0] adj;

    assign adj     = (r_digit >= ADJ_MIN) ? DIGIT_W'(r_digit + ADJ_ADD) : r_digit;
    assign o_carry = adj[DIGIT_W-1];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.conv) begin
            n_digit = {adj[DIGIT_W-2:0], i_carry};
        end else if (i_ctrl.shift) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

// File: rtl/signed_int_to_decimal_ascii_unit.sv
// Converts a signed 32-bit integer to its decimal ASCII text, one character
// per output item, most significant first, with a leading '-' for negative
// values, no leading zeros, and tlast on the final character (1 to 11 items).
// The magnitude goes bit-serially, MSB first, through a row of ten BCD digit
// cells (shift-and-add-3); the same cells then shift toward the top to drain
// the digits, skipping leading zeros and sending one character at a time,
// and an output stall holds the drain. A new item is accepted only once the
// last character sits in the output register.
module signed_int_to_decimal_ascii_unit
    import sitoa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [VALUE_W-1:0] i_s_tdata,   // [31:0] value (signed)
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [CHAR_W-1:0] o_m_tdata,    // [7:0] text_char
    output logic              o_m_tlast     // is_last
);

    localparam int CNT_W = $clog2(VALUE_W);
    localparam int LEFT_W = $clog2(NUM_DIGITS + 1);
    localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(VALUE_W - 1);
    localparam logic [LEFT_W-1:0] LEFT_FULL = LEFT_W'(NUM_DIGITS);
    localparam logic [LEFT_W-1:0] LEFT_ONE  = LEFT_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    t_state              r_state;
    logic [VALUE_W-1:0]  r_bin;
    logic [CNT_W-1:0]    r_bit_cnt;
    logic                r_neg;
    logic                r_lead;
    logic [LEFT_W-1:0]   r_left;
    logic                r_m_tvalid;
    logic [CHAR_W-1:0]   r_m_tdata;
    logic                r_m_tlast;

    t_cell_ctrl          cell_ctrl;
    logic [NUM_DIGITS:0] carry;
    logic [DIGIT_W-1:0]  digit [NUM_DIGITS];
    logic [DIGIT_W-1:0]  top_digit;
    logic                s_accept;
    logic                slot_free;
    logic                skip_zero;
    logic                emit_digit;
    logic                emit_minus;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign slot_free  = !r_m_tvalid || i_m_tready;
    assign top_digit  = digit[NUM_DIGITS-1];

    // zeros are skipped only ahead of the first digit sent
    assign emit_minus = (r_state == ST_EMIT) && r_neg && slot_free;
    assign skip_zero  = (r_state == ST_EMIT) && !r_neg && r_lead && (top_digit == '0)
                        && (r_left != LEFT_ONE);
    assign emit_digit = (r_state == ST_EMIT) && !r_neg && !skip_zero && slot_free;

    assign cell_ctrl.clear = s_accept;
    assign cell_ctrl.conv  = (r_state == ST_CONV);
    assign cell_ctrl.shift = skip_zero || emit_digit;

    assign carry[0] = r_bin[VALUE_W-1];

    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        sitoa_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (cell_ctrl),
            .i_carry (carry[g]),
            .i_digit ((g == 0) ? DIGIT_W'(0) : digit[(g == 0) ? 0 : g-1]),
            .o_carry (carry[g+1]),
            .o_digit (digit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_m_tvalid <= 1'b0;
            r_neg      <= 1'b0;
            r_lead     <= 1'b0;
            r_bit_cnt  <= '0;
            r_left     <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (s_accept) begin
                        r_neg     <= i_s_tdata[VALUE_W-1];
                        r_bin     <= i_s_tdata[VALUE_W-1] ? VALUE_W'(0) - i_s_tdata
                                                          : i_s_tdata;
                        r_bit_cnt <= '0;
                        r_state   <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    r_bin     <= {r_bin[VALUE_W-2:0], 1'b0};
                    r_bit_cnt <= CNT_W'(r_bit_cnt + 1'b1);
                    if (r_bit_cnt == CNT_LAST) begin
                        r_left  <= LEFT_FULL;
                        r_lead  <= 1'b1;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_minus) begin
                        r_neg <= 1'b0;
                    end
                    if (emit_digit) begin
                        r_lead <= 1'b0;
                    end
                    if (skip_zero || emit_digit) begin
                        r_left <= LEFT_W'(r_left - 1'b1);
                    end
                    if (emit_digit && (r_left == LEFT_ONE)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (emit_minus || emit_digit) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_minus) begin
            r_m_tdata <= ASCII_MINUS;
            r_m_tlast <= 1'b0;
        end else if (emit_digit) begin
            r_m_tdata <= CHAR_W'(ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit});
            r_m_tlast <= (r_left == LEFT_ONE);
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tlast  = r_m_tlast;

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_left != '0))
        else $error("digit count underflow");

    a_top_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV) |-> !carry[NUM_DIGITS])
        else $error("BCD chain overflow");

    a_top_is_bcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (top_digit <= DIGIT_MAX))
        else $error("non-BCD digit");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata == ASCII_MINUS)) |-> !o_m_tlast)
        else $error("minus sign flagged last");

    a_accept_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == ST_CONV) && (r_bit_cnt == '0))
        else $error("conversion did not start");

endmodule
